/* sv/wacm_pkg.sv */
package wacm_pkg;

	localparam int MAX_NODES_DEF = 1024;
	localparam int ALPHABET_DEF  = 10;
	localparam int NODE_W        = 10;
	localparam int WT_W          = 40;
	localparam int CNT_W         = 16;
	localparam int IN_WT_W       = 32;
	localparam int DIGIT_W       = 4;

	typedef enum logic [1:0] {
		KIND_PATTERN = 2'd0,
		KIND_BUILD   = 2'd1,
		KIND_MATCH   = 2'd2,
		KIND_RESTART = 2'd3
	} kind_t;

	// One classified command as it sits in the queue between front and back.
	typedef struct packed {
		kind_t                      kind;
		logic                       bad_digit;
		logic [DIGIT_W-1:0]         digit;
		logic                       last;
		logic signed [IN_WT_W-1:0]  weight;
	} op_t;

	function automatic logic signed [WT_W-1:0] sat_w(input logic signed [WT_W-1:0] a,
			input logic signed [WT_W-1:0] b);
		logic signed [WT_W:0] s;
		s = {a[WT_W-1], a} + {b[WT_W-1], b};
		if (s[WT_W] != s[WT_W-1])
			return s[WT_W] ? {1'b1, {(WT_W-1){1'b0}}} : {1'b0, {(WT_W-1){1'b1}}};
		return s[WT_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] sat_c(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

endpackage

/* sv/wacm_cmd_if.sv */
interface wacm_cmd_if;
	logic                                   valid;
	logic                                   ready;
	logic [1:0]                             kind;
	logic [wacm_pkg::DIGIT_W-1:0]           digit;
	logic                                   pattern_end;
	logic signed [wacm_pkg::IN_WT_W-1:0]    weight;

	modport source(output valid, kind, digit, pattern_end, weight, input ready);
	modport sink(input valid, kind, digit, pattern_end, weight, output ready);
endinterface

/* sv/wacm_res_if.sv */
interface wacm_res_if;
	logic                                   valid;
	logic                                   ready;
	logic [wacm_pkg::NODE_W-1:0]            node;
	logic signed [wacm_pkg::WT_W-1:0]       weight_total;
	logic [wacm_pkg::CNT_W-1:0]             match_count;
	logic                                   build_done;
	logic                                   rejected;

	modport source(output valid, node, weight_total, match_count, build_done, rejected,
		input ready);
	modport sink(input valid, node, weight_total, match_count, build_done, rejected,
		output ready);
endinterface

/* sv/wacm_ram.sv */
module wacm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* sv/wacm_front.sv */
module wacm_front #(
	parameter int ALPHABET = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	wacm_cmd_if.sink        cmd,
	output wacm_pkg::op_t   head,
	output logic            head_valid,
	input  logic            pop
);
	import wacm_pkg::*;

	op_t        ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	op_t        cls;

	assign cmd.ready  = (cnt_q != 2'd2);
	assign push       = cmd.valid && cmd.ready;
	assign head       = ent_q[rd_q];
	assign head_valid = (cnt_q != 2'd0);

	always_comb begin
		cls.kind      = kind_t'(cmd.kind);
		cls.bad_digit = ({5'd0, cmd.digit} >= 9'(ALPHABET));
		cls.digit     = cmd.digit;
		cls.last      = cmd.pattern_end;
		cls.weight    = cmd.weight;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

/* sv/wacm_back.sv */
module wacm_back #(
	parameter int MAX_NODES = 1024,
	parameter int ALPHABET  = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  wacm_pkg::op_t   head,
	input  logic            head_valid,
	output logic            pop,
	wacm_res_if.source      res
);
	import wacm_pkg::*;

	localparam int NW     = $clog2(MAX_NODES);
	localparam int GDEPTH = MAX_NODES * ALPHABET;
	localparam int GW     = $clog2(GDEPTH);
	localparam int AW     = $clog2(ALPHABET);
	localparam int NDW    = WT_W + CNT_W;

	typedef enum logic [15:0] {
		S_CLEAR  = 16'h0001,
		S_IDLE   = 16'h0002,
		S_P_RD   = 16'h0004,
		S_P_NW   = 16'h0008,
		S_M_GOTO = 16'h0010,
		S_M_NODE = 16'h0020,
		S_B_R0   = 16'h0040,
		S_B_R1   = 16'h0080,
		S_B_POP  = 16'h0100,
		S_B_U    = 16'h0200,
		S_B_F    = 16'h0400,
		S_B_NU   = 16'h0800,
		S_B_NF   = 16'h1000,
		S_B_GU   = 16'h2000,
		S_B_GF   = 16'h4000,
		S_B_GW   = 16'h8000
	} state_t;

	state_t         state_q;
	logic [GW-1:0]  clr_q;
	logic [NW-1:0]  cursor_q, match_q, nxt_q, u_q, f_q, v_q;
	logic [NW:0]    used_q, qhead_q, qtail_q;
	logic           built_q, drop_q, skip_q;
	logic [AW-1:0]  i_q;
	logic [GW-1:0]  ub_q, fb_q;
	logic [NDW-1:0] nu_q;
	op_t            op_q;

	logic           o_v_q;
	logic [NODE_W-1:0] o_node_q;
	logic signed [WT_W-1:0] o_w_q;
	logic [CNT_W-1:0] o_c_q;
	logic           o_b_q;
	logic           o_r_q;

	// Memory ports
	logic g_we, g_re, f_we, f_re, n_we, n_re, q_we, q_re;
	logic [GW-1:0]  g_waddr, g_raddr;
	logic [NW-1:0]  g_wdata, g_rdata;
	logic [NW-1:0]  f_waddr, f_raddr, f_wdata, f_rdata;
	logic [NW-1:0]  n_waddr, n_raddr;
	logic [NDW-1:0] n_wdata, n_rdata;
	logic [NW-1:0]  q_waddr, q_raddr, q_wdata, q_rdata;

	logic           full, tail_ok, last_i, emits;
	logic [NW-1:0]  pnxt;

	wacm_ram #(.WIDTH(NW),  .DEPTH(GDEPTH))    u_goto (.clk(clk), .we(g_we), .waddr(g_waddr),
		.wdata(g_wdata), .re(g_re), .raddr(g_raddr), .rdata(g_rdata));
	wacm_ram #(.WIDTH(NW),  .DEPTH(MAX_NODES)) u_fail (.clk(clk), .we(f_we), .waddr(f_waddr),
		.wdata(f_wdata), .re(f_re), .raddr(f_raddr), .rdata(f_rdata));
	wacm_ram #(.WIDTH(NDW), .DEPTH(MAX_NODES)) u_node (.clk(clk), .we(n_we), .waddr(n_waddr),
		.wdata(n_wdata), .re(n_re), .raddr(n_raddr), .rdata(n_rdata));
	wacm_ram #(.WIDTH(NW),  .DEPTH(MAX_NODES)) u_bfsq (.clk(clk), .we(q_we), .waddr(q_waddr),
		.wdata(q_wdata), .re(q_re), .raddr(q_raddr), .rdata(q_rdata));

	assign full    = (used_q >= (NW+1)'(MAX_NODES));
	assign tail_ok = (qtail_q < (NW+1)'(MAX_NODES));
	assign last_i  = (i_q == AW'(ALPHABET - 1));
	assign pnxt    = (g_rdata != '0) ? g_rdata : used_q[NW-1:0];
	assign emits   = (head.kind == KIND_BUILD) || (head.kind == KIND_MATCH);
	assign pop     = (state_q == S_IDLE) && head_valid && !(emits && o_v_q);

	assign res.valid        = o_v_q;
	assign res.node         = o_node_q;
	assign res.weight_total = o_w_q;
	assign res.match_count  = o_c_q;
	assign res.build_done   = o_b_q;
	assign res.rejected     = o_r_q;

	always_comb begin
		g_we = 1'b0; g_re = 1'b0; g_waddr = '0; g_raddr = '0; g_wdata = '0;
		f_we = 1'b0; f_re = 1'b0; f_waddr = '0; f_raddr = '0; f_wdata = '0;
		n_we = 1'b0; n_re = 1'b0; n_waddr = '0; n_raddr = '0; n_wdata = '0;
		q_we = 1'b0; q_re = 1'b0; q_waddr = '0; q_raddr = '0; q_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				g_we    = 1'b1;
				g_waddr = clr_q;
				f_we    = (clr_q < GW'(MAX_NODES));
				f_waddr = clr_q[NW-1:0];
				n_we    = f_we;
				n_waddr = clr_q[NW-1:0];
			end
			S_IDLE: begin
				if (pop && head.kind == KIND_PATTERN) begin
					g_re    = 1'b1;
					g_raddr = GW'(cursor_q) * GW'(ALPHABET) + GW'(head.digit);
				end else if (pop && head.kind == KIND_MATCH) begin
					if (head.bad_digit) begin
						n_re = 1'b1;
					end else begin
						g_re    = 1'b1;
						g_raddr = GW'(match_q) * GW'(ALPHABET) + GW'(head.digit);
					end
				end
			end
			S_P_RD: begin
				if (!(g_rdata == '0 && full)) begin
					g_we    = (g_rdata == '0);
					g_waddr = GW'(cursor_q) * GW'(ALPHABET) + GW'(op_q.digit);
					g_wdata = used_q[NW-1:0];
					n_re    = op_q.last;
					n_raddr = pnxt;
				end
			end
			S_P_NW: begin
				n_we    = 1'b1;
				n_waddr = nxt_q;
				n_wdata = {sat_w(n_rdata[NDW-1:CNT_W], WT_W'(op_q.weight)),
					sat_c(n_rdata[CNT_W-1:0], CNT_W'(1))};
			end
			S_M_GOTO: begin
				n_re    = 1'b1;
				n_raddr = g_rdata;
			end
			S_B_R0: begin
				g_re    = 1'b1;
				g_raddr = GW'(i_q);
			end
			S_B_R1: begin
				if (g_rdata != '0 && tail_ok) begin
					f_we    = 1'b1;
					f_waddr = g_rdata;
					q_we    = 1'b1;
					q_waddr = qtail_q[NW-1:0];
					q_wdata = g_rdata;
				end
			end
			S_B_POP: begin
				q_re    = (qhead_q < qtail_q);
				q_raddr = qhead_q[NW-1:0];
			end
			S_B_U: begin
				f_re    = 1'b1;
				f_raddr = q_rdata;
			end
			S_B_F: begin
				n_re    = 1'b1;
				n_raddr = u_q;
			end
			S_B_NU: begin
				n_re    = 1'b1;
				n_raddr = f_q;
			end
			S_B_NF: begin
				n_we    = 1'b1;
				n_waddr = u_q;
				n_wdata = {sat_w(nu_q[NDW-1:CNT_W], n_rdata[NDW-1:CNT_W]),
					sat_c(nu_q[CNT_W-1:0], n_rdata[CNT_W-1:0])};
			end
			S_B_GU: begin
				g_re    = 1'b1;
				g_raddr = ub_q + GW'(i_q);
			end
			S_B_GF: begin
				g_re    = 1'b1;
				g_raddr = fb_q + GW'(i_q);
			end
			S_B_GW: begin
				if (v_q != '0) begin
					f_we    = 1'b1;
					f_waddr = v_q;
					f_wdata = g_rdata;
					q_we    = tail_ok;
					q_waddr = qtail_q[NW-1:0];
					q_wdata = v_q;
				end else begin
					g_we    = 1'b1;
					g_waddr = ub_q + GW'(i_q);
					g_wdata = g_rdata;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= head;
		end
		case (state_q)
			S_P_RD:   nxt_q <= pnxt;
			S_B_U: begin
				u_q  <= q_rdata;
				ub_q <= GW'(q_rdata) * GW'(ALPHABET);
			end
			S_B_F: begin
				f_q  <= f_rdata;
				fb_q <= GW'(f_rdata) * GW'(ALPHABET);
			end
			S_B_NU:   nu_q <= n_rdata;
			S_B_GF:   v_q  <= g_rdata;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			cursor_q <= '0;
			match_q  <= '0;
			used_q   <= (NW+1)'(1);
			qhead_q  <= '0;
			qtail_q  <= '0;
			built_q  <= 1'b0;
			drop_q   <= 1'b0;
			skip_q   <= 1'b0;
			i_q      <= '0;
			o_v_q    <= 1'b0;
			o_node_q <= '0;
			o_w_q    <= '0;
			o_c_q    <= '0;
			o_b_q    <= 1'b0;
			o_r_q    <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				o_v_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + GW'(1);
					if (clr_q == GW'(GDEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (pop) begin
						case (head.kind)
							KIND_RESTART: match_q <= '0;
							KIND_PATTERN: begin
								if (built_q) begin
									drop_q <= 1'b1;
								end else if (skip_q || head.bad_digit) begin
									if (head.bad_digit && !skip_q) begin
										drop_q <= 1'b1;
									end
									skip_q <= !head.last;
									if (head.last) begin
										cursor_q <= '0;
									end
								end else begin
									state_q <= S_P_RD;
								end
							end
							KIND_MATCH: begin
								if (head.bad_digit) begin
									match_q <= '0;
									state_q <= S_M_NODE;
								end else begin
									state_q <= S_M_GOTO;
								end
							end
							KIND_BUILD: begin
								if (built_q) begin
									o_v_q    <= 1'b1;
									o_node_q <= '0;
									o_w_q    <= '0;
									o_c_q    <= '0;
									o_b_q    <= 1'b1;
									o_r_q    <= drop_q;
								end else begin
									built_q <= 1'b1;
									i_q     <= '0;
									state_q <= S_B_R0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_P_RD: begin
					if (g_rdata == '0 && full) begin
						drop_q   <= 1'b1;
						skip_q   <= !op_q.last;
						if (op_q.last) begin
							cursor_q <= '0;
						end
						state_q  <= S_IDLE;
					end else begin
						if (g_rdata == '0) begin
							used_q <= used_q + (NW+1)'(1);
						end
						if (op_q.last) begin
							state_q <= S_P_NW;
						end else begin
							cursor_q <= pnxt;
							state_q  <= S_IDLE;
						end
					end
				end
				S_P_NW: begin
					cursor_q <= '0;
					skip_q   <= 1'b0;
					state_q  <= S_IDLE;
				end
				S_M_GOTO: begin
					match_q <= g_rdata;
					state_q <= S_M_NODE;
				end
				S_M_NODE: begin
					o_v_q    <= 1'b1;
					o_node_q <= NODE_W'(match_q);
					o_w_q    <= n_rdata[NDW-1:CNT_W];
					o_c_q    <= n_rdata[CNT_W-1:0];
					o_b_q    <= 1'b0;
					o_r_q    <= drop_q;
					state_q  <= S_IDLE;
				end
				S_B_R0: state_q <= S_B_R1;
				S_B_R1: begin
					if (g_rdata != '0 && tail_ok) begin
						qtail_q <= qtail_q + (NW+1)'(1);
					end
					i_q     <= last_i ? '0 : i_q + AW'(1);
					state_q <= last_i ? S_B_POP : S_B_R0;
				end
				S_B_POP: begin
					if (qhead_q < qtail_q) begin
						qhead_q <= qhead_q + (NW+1)'(1);
						state_q <= S_B_U;
					end else begin
						o_v_q    <= 1'b1;
						o_node_q <= '0;
						o_w_q    <= '0;
						o_c_q    <= '0;
						o_b_q    <= 1'b1;
						o_r_q    <= drop_q;
						state_q  <= S_IDLE;
					end
				end
				S_B_U:  state_q <= S_B_F;
				S_B_F:  state_q <= S_B_NU;
				S_B_NU: state_q <= S_B_NF;
				S_B_NF: begin
					i_q     <= '0;
					state_q <= S_B_GU;
				end
				S_B_GU: state_q <= S_B_GF;
				S_B_GF: state_q <= S_B_GW;
				S_B_GW: begin
					if (v_q != '0 && tail_ok) begin
						qtail_q <= qtail_q + (NW+1)'(1);
					end
					i_q     <= last_i ? '0 : i_q + AW'(1);
					state_q <= last_i ? S_B_POP : S_B_GU;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* sv/weighted_aho_corasick_matcher.sv */
// Digit-string matcher with weighted patterns. Commands enter on cmd and
// results leave on res, both valid/ready channels; a transfer happens when
// valid and ready are high at a rising clock edge.
// Pattern digits build the trie one per transfer; a build command computes
// the fail links and folds fail-target weights and counts into every node;
// match digits step the automaton and report state, weight sum and count.
// Build and match commands give one result each, other commands none.
// A match result is registered once the back end has passed S_M_GOTO (which a
// bad match digit skips) and S_M_NODE. The back end handles one command at a
// time through single-port reads of the goto, fail and node memories: restarts,
// repeated builds and discarded pattern digits finish in S_IDLE, a pattern digit
// passes S_P_RD and a final one also S_P_NW. A first build scans the root in S_B_R0
// and S_B_R1, then per node S_B_POP to S_B_NF, per symbol S_B_GU to S_B_GW.
// After reset the block clears its memories over MAX_NODES*ALPHABET addresses
// (10240 by default); commands queue in the two-entry front queue meanwhile.
// When res is stalled the finished result waits in its output register,
// commands that need no result still proceed, and cmd backs up once the
// front queue is full.
module weighted_aho_corasick_matcher #(
	parameter int MAX_NODES = wacm_pkg::MAX_NODES_DEF,
	parameter int ALPHABET  = wacm_pkg::ALPHABET_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	wacm_cmd_if.sink  cmd,
	wacm_res_if.source res
);
	import wacm_pkg::*;

	op_t  head;
	logic head_valid;
	logic pop;

	wacm_front #(.ALPHABET(ALPHABET)) u_front (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.head(head), .head_valid(head_valid), .pop(pop)
	);

	wacm_back #(.MAX_NODES(MAX_NODES), .ALPHABET(ALPHABET)) u_back (
		.clk(clk), .arst_n(arst_n),
		.head(head), .head_valid(head_valid), .pop(pop), .res(res)
	);
endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
	import wacm_pkg::*;

	localparam int NODES    = MAX_NODES_DEF;
	localparam int SYMS     = ALPHABET_DEF;
	localparam int STALL_LIMIT = 200000;

	typedef struct {
		kind_t                      kind;
		logic [DIGIT_W-1:0]         digit;
		logic                       pend;
		logic signed [IN_WT_W-1:0]  weight;
	} cmd_item_t;

	typedef struct {
		logic [NODE_W-1:0]          node;
		logic signed [WT_W-1:0]     total;
		logic [CNT_W-1:0]           count;
		logic                       done;
		logic                       rej;
	} match_res_t;

	logic clk = 0;
	logic arst_n = 0;

	wacm_cmd_if cmd();
	wacm_res_if res();

	weighted_aho_corasick_matcher dut (.clk(clk), .arst_n(arst_n), .cmd(cmd), .res(res));

	always #4 clk = ~clk;

	// Automaton shadow state.
	logic [NODE_W-1:0]      trie_next [0:NODES*SYMS-1];
	logic [NODE_W-1:0]      fail_of [0:NODES-1];
	logic signed [WT_W-1:0] node_sum [0:NODES-1];
	logic [CNT_W-1:0]       node_cnt [0:NODES-1];
	int                     nodes_in_use = 1;
	int                     ins_node = 0;
	int                     cur_state = 0;
	bit                     is_built = 0;
	bit                     dropped = 0;
	bit                     skipping = 0;

	cmd_item_t  stim_q [$];
	match_res_t expected_q [$];
	int         n_issued = 0;
	int         n_acc = 0;
	int         cyc = 0;
	int         idle_cycles = 0;
	bit         failed = 0;
	bit         quiet;
	match_res_t got;
	match_res_t want;
	cmd_item_t  drv;

	function automatic logic signed [WT_W-1:0] clamp_add(logic signed [WT_W-1:0] a,
			logic signed [WT_W-1:0] b);
		longint s;
		s = longint'(a) + longint'(b);
		if (s > 64'sd549755813887) return 40'sh7F_FFFF_FFFF;
		if (s < -64'sd549755813888) return 40'sh80_0000_0000;
		return s[WT_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] cnt_inc(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
		int s;
		s = int'(a) + int'(b);
		return (s > 65535) ? 16'hFFFF : s[CNT_W-1:0];
	endfunction

	function automatic void add_pattern_digit(int d, bit last, logic signed [IN_WT_W-1:0] w);
		int slot;
		int nxt;
		if (is_built) begin
			dropped = 1;
			return;
		end
		if (!skipping) begin
			if (d >= SYMS) begin
				dropped = 1;
				skipping = 1;
			end else begin
				slot = ins_node * SYMS + d;
				nxt = trie_next[slot];
				if (nxt == 0) begin
					if (nodes_in_use >= NODES) begin
						dropped = 1;
						skipping = 1;
					end else begin
						nxt = nodes_in_use;
						nodes_in_use++;
						trie_next[slot] = nxt;
					end
				end
				if (!skipping) begin
					ins_node = nxt;
					if (last) begin
						node_sum[nxt] = clamp_add(node_sum[nxt], WT_W'(w));
						node_cnt[nxt] = cnt_inc(node_cnt[nxt], CNT_W'(1));
					end
				end
			end
		end
		if (last) begin
			ins_node = 0;
			skipping = 0;
		end
	endfunction

	function automatic void build_links();
		int order [$];
		int u;
		int f;
		int v;
		int t;
		if (is_built) return;
		is_built = 1;
		for (int i = 0; i < SYMS; i++) begin
			if (trie_next[i] != 0) begin
				fail_of[trie_next[i]] = 0;
				order = {order, int'(trie_next[i])};
			end
		end
		while (order.size() != 0) begin
			u = order.pop_front();
			f = fail_of[u];
			node_sum[u] = clamp_add(node_sum[u], node_sum[f]);
			node_cnt[u] = cnt_inc(node_cnt[u], node_cnt[f]);
			for (int i = 0; i < SYMS; i++) begin
				v = trie_next[u*SYMS + i];
				t = trie_next[f*SYMS + i];
				if (v != 0) begin
					fail_of[v] = t;
					order = {order, v};
				end else begin
					trie_next[u*SYMS + i] = t;
				end
			end
		end
	endfunction

	function automatic void predict_step(kind_t k, int d, bit last,
			logic signed [IN_WT_W-1:0] w);
		match_res_t r;
		case (k)
			KIND_PATTERN: add_pattern_digit(d, last, w);
			KIND_RESTART: cur_state = 0;
			KIND_BUILD: begin
				build_links();
				r = '{node: '0, total: '0, count: '0, done: 1'b1, rej: dropped};
				expected_q = {expected_q, r};
			end
			default: begin
				cur_state = (d >= SYMS) ? 0 : trie_next[cur_state*SYMS + d];
				r = '{node: cur_state[NODE_W-1:0], total: node_sum[cur_state],
					count: node_cnt[cur_state], done: 1'b0, rej: dropped};
				expected_q = {expected_q, r};
			end
		endcase
	endfunction

	function automatic void queue_cmd(kind_t k, int d, bit last, logic signed [IN_WT_W-1:0] w);
		cmd_item_t it;
		it.kind = k;
		it.digit = d[DIGIT_W-1:0];
		it.pend = last;
		it.weight = w;
		stim_q = {stim_q, it};
	endfunction

	function automatic void queue_pattern(int len, int top);
		for (int i = 0; i < len; i++)
			queue_cmd(KIND_PATTERN, $urandom_range(top, 0), i == len - 1, $urandom);
	endfunction

	initial begin
		for (int i = 0; i < NODES*SYMS; i++) trie_next[i] = '0;
		for (int i = 0; i < NODES; i++) begin
			fail_of[i] = '0;
			node_sum[i] = '0;
			node_cnt[i] = '0;
		end
	end

	// Transfers on the command side drive the shadow automaton.
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (arst_n && cmd.valid && cmd.ready) begin
			predict_step(kind_t'(cmd.kind), cmd.digit, cmd.pattern_end, cmd.weight);
			n_acc <= n_acc + 1;
		end
	end

	assign quiet = (cyc % 3000) < 800;

	always @(negedge clk) begin
		if (arst_n) begin
			if (n_acc == n_issued) begin
				if (stim_q.size() != 0 && (quiet || $urandom_range(99) >= 37)) begin
					drv = stim_q.pop_front();
					cmd.kind <= drv.kind;
					cmd.digit <= drv.digit;
					cmd.pattern_end <= drv.pend;
					cmd.weight <= drv.weight;
					cmd.valid <= 1'b1;
					n_issued <= n_issued + 1;
				end else begin
					cmd.valid <= 1'b0;
				end
			end
			res.ready <= quiet || ($urandom_range(99) >= 37);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			got = '{node: res.node, total: res.weight_total, count: res.match_count,
				done: res.build_done, rej: res.rejected};
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result node %0d total %0d count %0d", $time,
					got.node, got.total, got.count);
				failed = 1;
			end else begin
				want = expected_q.pop_front();
				if (got.node !== want.node) begin
					$display("%0t: node expected %0d actual %0d", $time, want.node, got.node);
					failed = 1;
				end
				if (got.total !== want.total) begin
					$display("%0t: weight_total expected %0d actual %0d", $time,
						want.total, got.total);
					failed = 1;
				end
				if (got.count !== want.count) begin
					$display("%0t: match_count expected %0d actual %0d", $time,
						want.count, got.count);
					failed = 1;
				end
				if (got.done !== want.done) begin
					$display("%0t: build_done expected %0b actual %0b", $time,
						want.done, got.done);
					failed = 1;
				end
				if (got.rej !== want.rej) begin
					$display("%0t: rejected expected %0b actual %0b", $time,
						want.rej, got.rej);
					failed = 1;
				end
			end
		end
	end

	// The watchdog restarts whenever either channel makes a transfer.
	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (res.valid && res.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin
		int r;
		cmd.valid = 0;
		cmd.kind = '0;
		cmd.digit = '0;
		cmd.pattern_end = 0;
		cmd.weight = '0;
		res.ready = 0;

		// Matching on an empty trie, a bad match digit, a restart and the first patterns.
		queue_cmd(KIND_MATCH, 3, 0, 0);
		queue_cmd(KIND_MATCH, 15, 1, 32'h7FFF_FFFF);
		queue_cmd(KIND_RESTART, 9, 1, 32'h8000_0000);
		queue_cmd(KIND_PATTERN, 1, 1, 32'h7FFF_FFFF);
		queue_cmd(KIND_PATTERN, 1, 0, 0);
		queue_cmd(KIND_PATTERN, 2, 1, 32'h8000_0000);
		queue_cmd(KIND_PATTERN, 2, 1, 1);
		// A bad digit in the middle of a pattern drops the rest of it.
		queue_cmd(KIND_PATTERN, 1, 0, 0);
		queue_cmd(KIND_PATTERN, 15, 0, 0);
		queue_cmd(KIND_PATTERN, 2, 1, 5);
		queue_cmd(KIND_PATTERN, 3, 0, 0);
		queue_cmd(KIND_PATTERN, 4, 1, -7);
		queue_cmd(KIND_MATCH, 1, 0, 0);
		queue_cmd(KIND_MATCH, 2, 0, 0);
		queue_cmd(KIND_MATCH, 1, 0, 0);
		queue_cmd(KIND_MATCH, 1, 0, 0);
		queue_cmd(KIND_RESTART, 0, 0, 0);
		queue_cmd(KIND_MATCH, 3, 0, 0);
		queue_cmd(KIND_MATCH, 4, 0, 0);
		queue_cmd(KIND_MATCH, 10, 0, 0);

		// Enough extreme weights on one node to saturate it on insert, and a
		// pattern whose fail target is that node, which saturates during the build.
		for (int i = 0; i < 260; i++) queue_cmd(KIND_PATTERN, 5, 1, 32'h7FFF_FFFF);
		queue_cmd(KIND_PATTERN, 6, 0, 0);
		queue_cmd(KIND_PATTERN, 5, 1, 32'h7FFF_FFFF);
		queue_cmd(KIND_MATCH, 5, 0, 0);
		queue_cmd(KIND_MATCH, 6, 0, 0);

		// Short overlapping patterns over a small alphabet, with matches, restarts and bad-digit patterns mixed in.
		for (int i = 0; i < 20; i++) begin
			r = $urandom_range(99);
			if (r < 70) queue_pattern($urandom_range(4, 1), 3);
			else if (r < 90) queue_cmd(KIND_MATCH, $urandom_range(3, 0), $urandom, $urandom);
			else if (r < 95) queue_cmd(KIND_RESTART, $urandom_range(15, 0), $urandom, $urandom);
			else queue_cmd(KIND_PATTERN, $urandom_range(15, 10), 1, $urandom);
		end

		// Long random patterns grow deep branches of the trie.
		for (int i = 0; i < 8; i++) queue_pattern(20, 9);
		queue_pattern(3, 3);

		queue_cmd(KIND_BUILD, $urandom_range(15, 0), $urandom, $urandom);
		queue_cmd(KIND_BUILD, $urandom_range(15, 0), $urandom, $urandom);
		queue_cmd(KIND_PATTERN, 2, 1, 100);

		for (int i = 0; i < 100; i++) begin
			r = $urandom_range(99);
			if (r < 70)
				queue_cmd(KIND_MATCH, $urandom_range(3, 0), $urandom, $urandom);
			else if (r < 85)
				queue_cmd(KIND_MATCH, $urandom_range(9, 0), $urandom, $urandom);
			else if (r < 92)
				queue_cmd(KIND_RESTART, $urandom_range(15, 0), $urandom, $urandom);
			else
				queue_cmd(KIND_MATCH, $urandom_range(15, 10), $urandom, $urandom);
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		while (stim_q.size() != 0 || n_acc != n_issued || expected_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (!failed && expected_q.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
